// ===== src/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// shs_pkg
// shared widths, register indexes, command/status structs and helpers for
// the slope engine
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

    localparam int PIX_W   = 16;
    localparam int ROW_W   = 2;
    localparam int FLUX_W  = 20;
    localparam int COM_W   = 22;
    localparam int QUAD_W  = 20;
    localparam int TOT_W   = 26;
    localparam int SQT_W   = 41;
    localparam int AVG_W   = 20;
    localparam int GAIN_W  = 16;
    localparam int SLOPE_W = 16;
    localparam int NUM_W   = 10;
    localparam int APF_W   = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // shared divider and square root unit
    localparam int DIV_N_W = 41;
    localparam int DIV_D_W = 20;
    localparam int RT_W    = 21;

    localparam logic              MODE_RESET = 1'b1;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTROID_MODE = 2'd0,
        CFG_PEAK_GAIN     = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DIV_DX = 3'd0,
        DIV_DY = 3'd1,
        DIV_MX = 3'd2,
        DIV_MY = 3'd3,
        DIV_MS = 3'd4
    } t_div_sel;

    typedef struct packed {
        logic     row_fire;
        logic     div_start;
        t_div_sel div_sel;
        logic     sq1;
        logic     sq2;
        logic     spot_out;
        logic     rt_start;
        logic     pk1;
        logic     pk2;
        logic     sum_out;
    } t_cmd;

    typedef struct packed {
        logic row_last;
        logic zero_flux;
        logic last;
        logic div_done;
        logic rt_done;
        logic out_free;
    } t_sts;

    // signed saturation of a magnitude and sign to a 16 bit slope
    function automatic logic signed [SLOPE_W-1:0] sat_slope(
        input logic [DIV_N_W-1:0] mag,
        input logic               neg
    );
        logic [SLOPE_W-1:0] res;
        if (neg) begin
            if (mag > DIV_N_W'(32768)) res = 16'h8000;
            else                       res = SLOPE_W'(0) - mag[SLOPE_W-1:0];
        end else begin
            if (mag > DIV_N_W'(32767)) res = 16'h7fff;
            else                       res = mag[SLOPE_W-1:0];
        end
        return $signed(res);
    endfunction

endpackage

`default_nettype wire

// ===== src/shs_div.sv =====
// ----------------------------------------------------------------------------
// shs_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module shs_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [shs_pkg::DIV_N_W-1:0] i_num,
    input  wire logic [shs_pkg::DIV_D_W-1:0] i_den,
    output logic                             o_done,
    output logic [shs_pkg::DIV_N_W-1:0]      o_quo
);

    localparam int STEPS = shs_pkg::DIV_N_W;
    localparam int CNT_W = $clog2(STEPS);

    logic                          r_busy, r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [shs_pkg::DIV_N_W-1:0]   r_quo;
    logic [shs_pkg::DIV_D_W-1:0]   r_rem, r_den, n_rem;
    logic [shs_pkg::DIV_D_W:0]     rem_sh, den_x, diff;
    logic                          ge;

    assign rem_sh = {r_rem, r_quo[shs_pkg::DIV_N_W-1]};
    assign den_x  = {1'b0, r_den};
    assign ge     = rem_sh >= den_x;
    assign diff   = rem_sh - den_x;
    assign n_rem  = ge ? diff[shs_pkg::DIV_D_W-1:0] : rem_sh[shs_pkg::DIV_D_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[shs_pkg::DIV_N_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== src/shs_sqrt.sv =====
// ----------------------------------------------------------------------------
// shs_sqrt
// digit by digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module shs_sqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [shs_pkg::SQT_W-1:0] i_rad,
    output logic                           o_done,
    output logic [shs_pkg::RT_W-1:0]       o_root
);

    localparam int STEPS = shs_pkg::RT_W;
    localparam int RAD_W = 2 * STEPS;
    localparam int REM_W = STEPS + 3;
    localparam int CNT_W = $clog2(STEPS);

    logic                       r_busy, r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [RAD_W-1:0]           r_rad;
    logic [REM_W-1:0]           r_rem, rem_sh, trial;
    logic [STEPS-1:0]           r_root;
    logic                       ge;

    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1:RAD_W-2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RAD_W'(i_rad);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[STEPS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== src/shs_datapath.sv =====
// ----------------------------------------------------------------------------
// shs_datapath
// window accumulators, frame totals, shared divider and root, output register
// ----------------------------------------------------------------------------
`default_nettype none

module shs_datapath #(
    parameter int MAX_SPOTS = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire shs_pkg::t_cmd                         i_cmd,
    output shs_pkg::t_sts                              o_sts,
    input  wire logic                                  i_cfg_valid,
    input  wire logic [shs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [shs_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic signed [shs_pkg::PIX_W-1:0]      i_pixel_col0,
    input  wire logic signed [shs_pkg::PIX_W-1:0]      i_pixel_col1,
    input  wire logic signed [shs_pkg::PIX_W-1:0]      i_pixel_col2,
    input  wire logic signed [shs_pkg::PIX_W-1:0]      i_pixel_col3,
    input  wire logic                                  i_final_spot,
    input  wire logic                                  i_out_ready,
    output logic                                       o_out_valid,
    output logic                                       o_result_kind,
    output logic [shs_pkg::NUM_W-1:0]                  o_spot_number,
    output logic signed [shs_pkg::SLOPE_W-1:0]         o_spot_dx,
    output logic signed [shs_pkg::SLOPE_W-1:0]         o_spot_dy,
    output logic signed [shs_pkg::FLUX_W-1:0]          o_spot_flux,
    output logic                                       o_zero_flux,
    output logic signed [shs_pkg::SLOPE_W-1:0]         o_mean_slope_x,
    output logic signed [shs_pkg::SLOPE_W-1:0]         o_mean_slope_y,
    output logic [shs_pkg::SLOPE_W-1:0]                o_rms_residual,
    output logic [shs_pkg::APF_W-1:0]                  o_avg_peak_flux,
    output logic                                       o_last_of_run
);

    localparam int CW = (MAX_SPOTS > 1) ? $clog2(MAX_SPOTS) : 1;
    localparam int NW = shs_pkg::DIV_N_W + 1;
    localparam int AW = 24;

    // configuration
    logic                        r_mode_cfg;
    logic [shs_pkg::GAIN_W-1:0]  r_gain;

    // window state
    logic [shs_pkg::ROW_W-1:0]   r_row;
    logic [shs_pkg::FLUX_W-1:0]  r_flux;
    logic [shs_pkg::COM_W-1:0]   r_cx, r_cy;
    logic [shs_pkg::QUAD_W-1:0]  r_qx, r_qy;
    logic                        r_last, r_mode;
    logic signed [shs_pkg::SLOPE_W-1:0] r_dx, r_dy, r_mx, r_my;

    // frame state
    logic [CW-1:0]                      r_cnt;
    logic signed [shs_pkg::FLUX_W-1:0]  r_peak;
    logic signed [shs_pkg::TOT_W-1:0]   r_tx, r_ty;
    logic [shs_pkg::SQT_W-1:0]          r_sqt, r_msq;
    logic [shs_pkg::AVG_W-1:0]          r_avg;
    logic [31:0]                        r_prod, r_sq;
    logic [35:0]                        r_pprod;
    logic [shs_pkg::SLOPE_W-1:0]        r_rms;

    // output register
    logic                               r_ov;

    // row contributions
    logic signed [AW-1:0] p0, p1, p2, p3, rs, d30, cx_add, cy_add, qx_add, qy_add;

    assign p0 = AW'(i_pixel_col0);
    assign p1 = AW'(i_pixel_col1);
    assign p2 = AW'(i_pixel_col2);
    assign p3 = AW'(i_pixel_col3);
    assign rs  = p0 + p1 + p2 + p3;
    assign d30 = p3 - p0;
    assign cx_add = (d30 <<< 1) + d30 + (p2 - p1);
    assign qx_add = (p2 + p3) - (p0 + p1);
    assign qy_add = (r_row < 2'd2) ? -rs : rs;

    always_comb begin
        case (r_row)
            2'd0:    cy_add = -((rs <<< 1) + rs);
            2'd1:    cy_add = -rs;
            2'd2:    cy_add = rs;
            2'd3:    cy_add = (rs <<< 1) + rs;
            default: cy_add = rs;
        endcase
    end

    // divider operands
    logic signed [NW-1:0]            num_s;
    logic [shs_pkg::DIV_N_W-1:0]     num_mag;
    logic [shs_pkg::DIV_D_W-1:0]     den, flux_mag, cnt_den;
    logic                            num_neg, res_neg, flux_neg;
    logic [CW:0]                     cnt1;
    logic signed [NW-1:0]            numx, numy;

    assign flux_neg = r_flux[shs_pkg::FLUX_W-1];
    assign flux_mag = flux_neg ? (shs_pkg::DIV_D_W'(0) - r_flux) : r_flux;
    assign cnt1     = (CW + 1)'(r_cnt) + (CW + 1)'(1);
    assign cnt_den  = shs_pkg::DIV_D_W'(cnt1);
    assign numx = r_mode ? $signed({{7{r_cx[shs_pkg::COM_W-1]}}, r_cx, 13'b0})
                         : $signed({{8{r_qx[shs_pkg::QUAD_W-1]}}, r_qx, 14'b0});
    assign numy = r_mode ? $signed({{7{r_cy[shs_pkg::COM_W-1]}}, r_cy, 13'b0})
                         : $signed({{8{r_qy[shs_pkg::QUAD_W-1]}}, r_qy, 14'b0});

    always_comb begin
        case (i_cmd.div_sel)
            shs_pkg::DIV_DX: begin
                num_s = numx;
                den   = flux_mag;
            end
            shs_pkg::DIV_DY: begin
                num_s = numy;
                den   = flux_mag;
            end
            shs_pkg::DIV_MX: begin
                num_s = NW'(r_tx);
                den   = cnt_den;
            end
            shs_pkg::DIV_MY: begin
                num_s = NW'(r_ty);
                den   = cnt_den;
            end
            default: begin
                num_s = $signed({1'b0, r_sqt});
                den   = cnt_den;
            end
        endcase
        num_neg = num_s[NW-1];
        num_mag = num_neg ? shs_pkg::DIV_N_W'(-num_s) : num_s[shs_pkg::DIV_N_W-1:0];
        res_neg = ((i_cmd.div_sel == shs_pkg::DIV_DX) || (i_cmd.div_sel == shs_pkg::DIV_DY))
                ? (num_neg ^ flux_neg) : num_neg;
    end

    logic                          div_done, rt_done;
    logic [shs_pkg::DIV_N_W-1:0]   quo;
    logic [shs_pkg::RT_W-1:0]      root;
    logic signed [shs_pkg::SLOPE_W-1:0] q_sat;

    assign q_sat = shs_pkg::sat_slope(quo, res_neg);

    shs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num_mag),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    shs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.rt_start),
        .i_rad   (r_msq),
        .o_done  (rt_done),
        .o_root  (root)
    );

    // frame total updates
    logic signed [shs_pkg::TOT_W:0]  tx_sum, ty_sum;
    logic signed [shs_pkg::TOT_W-1:0] n_tx, n_ty;
    logic [shs_pkg::SQT_W:0]         sq_sum;
    logic signed [31:0]              dy_sq;
    logic [16:0]                     inv_g;
    logic [36:0]                     m2;
    logic [37:0]                     wsum;

    localparam logic signed [shs_pkg::TOT_W:0] TOT_HI = (1 <<< (shs_pkg::TOT_W - 1)) - 1;
    localparam logic signed [shs_pkg::TOT_W:0] TOT_LO = -(1 <<< (shs_pkg::TOT_W - 1));

    assign tx_sum = (shs_pkg::TOT_W + 1)'(r_tx) + (shs_pkg::TOT_W + 1)'(r_dx);
    assign ty_sum = (shs_pkg::TOT_W + 1)'(r_ty) + (shs_pkg::TOT_W + 1)'(r_dy);
    assign n_tx = (tx_sum > TOT_HI) ? shs_pkg::TOT_W'(TOT_HI)
                : (tx_sum < TOT_LO) ? shs_pkg::TOT_W'(TOT_LO) : shs_pkg::TOT_W'(tx_sum);
    assign n_ty = (ty_sum > TOT_HI) ? shs_pkg::TOT_W'(TOT_HI)
                : (ty_sum < TOT_LO) ? shs_pkg::TOT_W'(TOT_LO) : shs_pkg::TOT_W'(ty_sum);
    assign sq_sum = {1'b0, r_sqt} + (shs_pkg::SQT_W + 1)'(r_sq);
    assign dy_sq  = r_dy * r_dy;
    assign inv_g  = 17'h10000 - {1'b0, r_gain};
    assign m2     = inv_g * r_avg;
    assign wsum   = 38'(r_pprod) + 38'(m2) + 38'd32768;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_cfg <= shs_pkg::MODE_RESET;
            r_gain     <= shs_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (shs_pkg::t_cfg_idx'(i_cfg_index))
                shs_pkg::CFG_CENTROID_MODE: r_mode_cfg <= i_cfg_data[0];
                shs_pkg::CFG_PEAK_GAIN:     r_gain     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_flux <= '0;
            r_cx   <= '0;
            r_cy   <= '0;
            r_qx   <= '0;
            r_qy   <= '0;
            r_last <= 1'b0;
            r_cnt  <= '0;
            r_peak <= '0;
            r_tx   <= '0;
            r_ty   <= '0;
            r_sqt  <= '0;
            r_avg  <= '0;
        end else begin
            if (i_cmd.row_fire) begin
                r_row  <= r_row + 2'd1;
                r_flux <= r_flux + rs[shs_pkg::FLUX_W-1:0];
                r_cx   <= r_cx + cx_add[shs_pkg::COM_W-1:0];
                r_cy   <= r_cy + cy_add[shs_pkg::COM_W-1:0];
                r_qx   <= r_qx + qx_add[shs_pkg::QUAD_W-1:0];
                r_qy   <= r_qy + qy_add[shs_pkg::QUAD_W-1:0];
                if (r_row == 2'd3) begin
                    r_last <= i_final_spot;
                end
            end
            if (i_cmd.spot_out) begin
                r_flux <= '0;
                r_cx   <= '0;
                r_cy   <= '0;
                r_qx   <= '0;
                r_qy   <= '0;
                if ($signed(r_flux) > r_peak) begin
                    r_peak <= $signed(r_flux);
                end
                r_tx  <= n_tx;
                r_ty  <= n_ty;
                r_sqt <= sq_sum[shs_pkg::SQT_W] ? '1 : sq_sum[shs_pkg::SQT_W-1:0];
                if (!r_last && (r_cnt < CW'(MAX_SPOTS - 1))) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            if (i_cmd.pk2) begin
                r_avg <= wsum[35:16];
            end
            if (i_cmd.sum_out) begin
                r_cnt  <= '0;
                r_peak <= '0;
                r_tx   <= '0;
                r_ty   <= '0;
                r_sqt  <= '0;
            end
        end
    end

    // per item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_fire && (r_row == 2'd3)) begin
            r_mode <= r_mode_cfg;
            r_dx   <= '0;
            r_dy   <= '0;
        end
        if (div_done) begin
            case (i_cmd.div_sel)
                shs_pkg::DIV_DX: r_dx  <= q_sat;
                shs_pkg::DIV_DY: r_dy  <= q_sat;
                shs_pkg::DIV_MX: r_mx  <= q_sat;
                shs_pkg::DIV_MY: r_my  <= q_sat;
                default:         r_msq <= quo;
            endcase
        end
        if (i_cmd.sq1) begin
            r_prod <= 32'(r_dx * r_dx);
        end
        if (i_cmd.sq2) begin
            r_sq <= r_prod + 32'(dy_sq);
        end
        if (rt_done) begin
            r_rms <= (root > shs_pkg::RT_W'(65535)) ? 16'hffff : root[15:0];
        end
        if (i_cmd.pk1) begin
            r_pprod <= r_gain * r_peak[shs_pkg::FLUX_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.spot_out || i_cmd.sum_out) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.spot_out) begin
            o_result_kind   <= 1'b0;
            o_spot_number   <= shs_pkg::NUM_W'(r_cnt);
            o_spot_dx       <= r_dx;
            o_spot_dy       <= r_dy;
            o_spot_flux     <= $signed(r_flux);
            o_zero_flux     <= (r_flux == '0);
            o_mean_slope_x  <= '0;
            o_mean_slope_y  <= '0;
            o_rms_residual  <= '0;
            o_avg_peak_flux <= '0;
            o_last_of_run   <= !r_last;
        end else if (i_cmd.sum_out) begin
            o_result_kind   <= 1'b1;
            o_spot_number   <= shs_pkg::NUM_W'(r_cnt);
            o_spot_dx       <= '0;
            o_spot_dy       <= '0;
            o_spot_flux     <= '0;
            o_zero_flux     <= 1'b0;
            o_mean_slope_x  <= r_mx;
            o_mean_slope_y  <= r_my;
            o_rms_residual  <= r_rms;
            o_avg_peak_flux <= r_avg[shs_pkg::APF_W-1:0];
            o_last_of_run   <= 1'b1;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_sts.row_last  = (r_row == 2'd3);
    assign o_sts.zero_flux = (r_flux == '0);
    assign o_sts.last      = r_last;
    assign o_sts.div_done  = div_done;
    assign o_sts.rt_done   = rt_done;
    assign o_sts.out_free  = !r_ov || i_out_ready;

endmodule

`default_nettype wire

// ===== src/shs_ctrl.sv =====
// ----------------------------------------------------------------------------
// shs_ctrl
// sequencer for window completion, spot result and frame summary
// ----------------------------------------------------------------------------
`default_nettype none

module shs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire shs_pkg::t_sts i_sts,
    output shs_pkg::t_cmd      o_cmd
);

    typedef enum logic [18:0] {
        S_IDLE     = 19'h00001,
        S_DX_GO    = 19'h00002,
        S_DX_WAIT  = 19'h00004,
        S_DY_GO    = 19'h00008,
        S_DY_WAIT  = 19'h00010,
        S_SQ1      = 19'h00020,
        S_SQ2      = 19'h00040,
        S_SPOT_OUT = 19'h00080,
        S_MX_GO    = 19'h00100,
        S_MX_WAIT  = 19'h00200,
        S_MY_GO    = 19'h00400,
        S_MY_WAIT  = 19'h00800,
        S_MS_GO    = 19'h01000,
        S_MS_WAIT  = 19'h02000,
        S_RT_GO    = 19'h04000,
        S_RT_WAIT  = 19'h08000,
        S_PK1      = 19'h10000,
        S_PK2      = 19'h20000,
        S_SUM_OUT  = 19'h40000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.div_sel = shs_pkg::DIV_DX;
        o_in_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.row_fire = 1'b1;
                    if (i_sts.row_last) n_state = S_DX_GO;
                end
            end
            S_DX_GO: begin
                if (i_sts.zero_flux) begin
                    n_state = S_SQ1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DX_WAIT;
                end
            end
            S_DX_WAIT: begin
                if (i_sts.div_done) n_state = S_DY_GO;
            end
            S_DY_GO: begin
                o_cmd.div_sel   = shs_pkg::DIV_DY;
                o_cmd.div_start = 1'b1;
                n_state         = S_DY_WAIT;
            end
            S_DY_WAIT: begin
                o_cmd.div_sel = shs_pkg::DIV_DY;
                if (i_sts.div_done) n_state = S_SQ1;
            end
            S_SQ1: begin
                o_cmd.sq1 = 1'b1;
                n_state   = S_SQ2;
            end
            S_SQ2: begin
                o_cmd.sq2 = 1'b1;
                n_state   = S_SPOT_OUT;
            end
            S_SPOT_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.spot_out = 1'b1;
                    n_state        = i_sts.last ? S_MX_GO : S_IDLE;
                end
            end
            S_MX_GO: begin
                o_cmd.div_sel   = shs_pkg::DIV_MX;
                o_cmd.div_start = 1'b1;
                n_state         = S_MX_WAIT;
            end
            S_MX_WAIT: begin
                o_cmd.div_sel = shs_pkg::DIV_MX;
                if (i_sts.div_done) n_state = S_MY_GO;
            end
            S_MY_GO: begin
                o_cmd.div_sel   = shs_pkg::DIV_MY;
                o_cmd.div_start = 1'b1;
                n_state         = S_MY_WAIT;
            end
            S_MY_WAIT: begin
                o_cmd.div_sel = shs_pkg::DIV_MY;
                if (i_sts.div_done) n_state = S_MS_GO;
            end
            S_MS_GO: begin
                o_cmd.div_sel   = shs_pkg::DIV_MS;
                o_cmd.div_start = 1'b1;
                n_state         = S_MS_WAIT;
            end
            S_MS_WAIT: begin
                o_cmd.div_sel = shs_pkg::DIV_MS;
                if (i_sts.div_done) n_state = S_RT_GO;
            end
            S_RT_GO: begin
                o_cmd.rt_start = 1'b1;
                n_state        = S_RT_WAIT;
            end
            S_RT_WAIT: begin
                if (i_sts.rt_done) n_state = S_PK1;
            end
            S_PK1: begin
                o_cmd.pk1 = 1'b1;
                n_state   = S_PK2;
            end
            S_PK2: begin
                o_cmd.pk2 = 1'b1;
                n_state   = S_SUM_OUT;
            end
            S_SUM_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.sum_out = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/shack_hartmann_slope_engine.sv =====
// ----------------------------------------------------------------------------
// shack_hartmann_slope_engine
// per-spot centroid or quad slopes, per-frame slope statistics, 4x4 windows
// ----------------------------------------------------------------------------
// usage:
//  - input channel (i_in_valid / o_in_ready): one transfer per window row,
//    row 0 first; i_final_spot is looked at only on the fourth row
//  - output channel (o_out_valid / i_out_ready): a spot result after each
//    fourth row, followed by a frame summary when that row was marked final
//  - config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is
//    the centroid mode, index 1 the peak averaging gain; other indexes are
//    dropped; write only while the block is idle
//  - rows one to three are accumulated while the sequencer stays in idle
//  - the fourth row starts the sequencer: two shared divider passes
//    (41 steps each) and the squaring states S_SQ1, S_SQ2 run before
//    the spot result enters the output register; zero flux skips the divider
//  - a frame summary adds three divider passes, a 21-step root and the
//    peak averaging states S_PK1 and S_PK2
//  - the next row is taken as soon as the sequencer is back in idle, even
//    while the last result still waits in the output register
//  - a stalled receiver holds the sequencer only when a new result must be
//    loaded and the output register is still full
//  - reset returns the config registers to their defaults and clears the
//    window accumulators and frame totals including the averaged peak flux
// ----------------------------------------------------------------------------
`default_nettype none

module shack_hartmann_slope_engine #(
    parameter int MAX_SPOTS = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // config channel
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [shs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [shs_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // row input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic signed [shs_pkg::PIX_W-1:0]      i_pixel_col0,
    input  wire logic signed [shs_pkg::PIX_W-1:0]      i_pixel_col1,
    input  wire logic signed [shs_pkg::PIX_W-1:0]      i_pixel_col2,
    input  wire logic signed [shs_pkg::PIX_W-1:0]      i_pixel_col3,
    input  wire logic                                  i_final_spot,
    // result output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic                                       o_result_kind,
    output logic [shs_pkg::NUM_W-1:0]                  o_spot_number,
    output logic signed [shs_pkg::SLOPE_W-1:0]         o_spot_dx,
    output logic signed [shs_pkg::SLOPE_W-1:0]         o_spot_dy,
    output logic signed [shs_pkg::FLUX_W-1:0]          o_spot_flux,
    output logic                                       o_zero_flux,
    output logic signed [shs_pkg::SLOPE_W-1:0]         o_mean_slope_x,
    output logic signed [shs_pkg::SLOPE_W-1:0]         o_mean_slope_y,
    output logic [shs_pkg::SLOPE_W-1:0]                o_rms_residual,
    output logic [shs_pkg::APF_W-1:0]                  o_avg_peak_flux,
    output logic                                       o_last_of_run
);

    shs_pkg::t_cmd cmd;
    shs_pkg::t_sts sts;

    // config writes never stall
    assign o_cfg_ready = 1'b1;

    // sequencer: owns the input handshake and steps the datapath
    shs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // accumulators, divider, root, frame totals and output register
    shs_datapath #(
        .MAX_SPOTS (MAX_SPOTS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pixel_col0    (i_pixel_col0),
        .i_pixel_col1    (i_pixel_col1),
        .i_pixel_col2    (i_pixel_col2),
        .i_pixel_col3    (i_pixel_col3),
        .i_final_spot    (i_final_spot),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_result_kind   (o_result_kind),
        .o_spot_number   (o_spot_number),
        .o_spot_dx       (o_spot_dx),
        .o_spot_dy       (o_spot_dy),
        .o_spot_flux     (o_spot_flux),
        .o_zero_flux     (o_zero_flux),
        .o_mean_slope_x  (o_mean_slope_x),
        .o_mean_slope_y  (o_mean_slope_y),
        .o_rms_residual  (o_rms_residual),
        .o_avg_peak_flux (o_avg_peak_flux),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

`default_nettype wire
